@@ src/mrct_pkg.sv @@
`timescale 1ns / 1ps
package mrct_pkg;

	localparam int MAX_PARAMS     = 4;
	localparam int MAX_VALUES     = 16;
	localparam int TABLE_DEPTH_DEF = 65536;

	typedef enum logic [2:0] {
		OP_FILL    = 3'd0,
		OP_DECODE  = 3'd1,
		OP_COUNT   = 3'd2,
		OP_CHECK   = 3'd3,
		OP_MARK    = 3'd4,
		OP_EXCLUDE = 3'd5,
		OP_VIOL    = 3'd6,
		OP_REOPEN  = 3'd7
	} op_t;

	localparam logic [1:0] MARK_OPEN     = 2'd0;
	localparam logic [1:0] MARK_COVERED  = 2'd1;
	localparam logic [1:0] MARK_EXCLUDED = 2'd2;
	localparam logic [1:0] MARK_BAD      = 2'd3;

	localparam logic [2:0] REG_PARAM_COUNT = 3'd0;
	localparam logic [2:0] REG_RADIX_0     = 3'd1;
	localparam logic [2:0] REG_RADIX_1     = 3'd2;
	localparam logic [2:0] REG_RADIX_2     = 3'd3;
	localparam logic [2:0] REG_RADIX_3     = 3'd4;
	localparam logic [2:0] REG_TABLE_RANGE = 3'd5;

	typedef struct packed {
		logic [2:0]      param_count;
		logic [3:0][4:0] radix;
		logic [16:0]     table_range;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic fill_step;
		logic div_step;
		logic kgen_step;
		logic scan_step;
		logic rd_issue;
		logic eval;
	} cmd_t;

	typedef struct packed {
		logic k_end;
		logic scan_end;
		logic div_last;
		logic kgen_last;
	} stat_t;

	typedef struct packed {
		logic [1:0]  key_status;
		logic [16:0] open_matches;
		logic [15:0] decoded_values;
		logic [2:0]  newly_bound;
		logic        violates;
		logic [16:0] open_total;
	} result_t;

endpackage

@@ src/mrct_ctrl.sv @@
`timescale 1ns / 1ps
module mrct_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  logic [2:0]        op,
	input  logic              foreign_terms,
	input  logic              rsp_valid,
	input  logic              rsp_ready,
	input  mrct_pkg::stat_t   stat,
	output logic              req_ready,
	output mrct_pkg::cmd_t    cmd,
	output logic              rsp_load
);

	typedef enum logic [2:0] {
		S_IDLE, S_FILL, S_KGEN, S_DIV, S_SCAN, S_READ, S_EVAL, S_FINISH
	} state_t;

	state_t          state_q;
	mrct_pkg::op_t   op_q;
	mrct_pkg::op_t   op_in;

	assign op_in = mrct_pkg::op_t'(op);

	assign req_ready     = (state_q == S_IDLE);
	assign cmd.load      = (state_q == S_IDLE) && req_valid;
	assign cmd.fill_step = (state_q == S_FILL);
	assign cmd.div_step  = (state_q == S_DIV);
	assign cmd.kgen_step = (state_q == S_KGEN);
	assign cmd.scan_step = (state_q == S_SCAN);
	assign cmd.rd_issue  = (state_q == S_READ);
	assign cmd.eval      = (state_q == S_EVAL);
	assign rsp_load      = (state_q == S_FINISH) && (!rsp_valid || rsp_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= mrct_pkg::OP_FILL;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						op_q <= op_in;
						unique case (op_in)
							mrct_pkg::OP_FILL:    state_q <= S_FILL;
							mrct_pkg::OP_DECODE,
							mrct_pkg::OP_CHECK:   state_q <= S_DIV;
							mrct_pkg::OP_COUNT:   state_q <= S_SCAN;
							mrct_pkg::OP_EXCLUDE: state_q <= foreign_terms ? S_FINISH : S_SCAN;
							mrct_pkg::OP_MARK,
							mrct_pkg::OP_VIOL:    state_q <= S_KGEN;
							default:              state_q <= S_READ;
						endcase
					end
				end
				S_FILL: begin
					if (stat.k_end) state_q <= S_FINISH;
				end
				S_DIV: begin
					if (stat.div_last)
						state_q <= (op_q == mrct_pkg::OP_CHECK) ? S_READ : S_FINISH;
				end
				S_KGEN: begin
					if (stat.kgen_last) state_q <= S_READ;
				end
				S_SCAN: begin
					if (stat.scan_end) state_q <= S_FINISH;
				end
				S_READ:  state_q <= S_EVAL;
				S_EVAL:  state_q <= S_FINISH;
				S_FINISH: begin
					if (!rsp_valid || rsp_ready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

@@ src/mrct_dpath.sv @@
`timescale 1ns / 1ps
module mrct_dpath #(
	parameter int TABLE_DEPTH = mrct_pkg::TABLE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  mrct_pkg::cfg_t    cfg,
	input  logic [2:0]        op,
	input  logic [15:0]       key,
	input  logic [3:0]        bound_mask,
	input  logic [15:0]       bound_values,
	input  logic [1:0]        fill_status,
	input  mrct_pkg::cmd_t    cmd,
	output mrct_pkg::stat_t   stat,
	output mrct_pkg::result_t res
);

	localparam int          ADDR_W = $clog2(TABLE_DEPTH);
	localparam logic [16:0] DEPTH  = 17'(TABLE_DEPTH);

	// effective configuration
	logic [2:0]      n;
	logic [3:0][4:0] r;
	logic [16:0]     lim;
	logic [3:0]      act;
	logic [3:0][3:0] bv;
	logic [3:0]      em;

	// item and sequencing registers
	mrct_pkg::op_t   op_q;
	logic [15:0]     key_q;
	logic [3:0]      mask_q;
	logic [15:0]     vals_q;
	logic [1:0]      fillm_q;
	logic [16:0]     k_q;
	logic [3:0][3:0] cdig_q;
	logic            wrap_q;
	logic [16:0]     matches_q;
	logic [16:0]     open_q;
	logic [16:0]     acc_q;
	logic [1:0]      pidx_q;
	logic [15:0]     dq_q;
	logic [4:0]      rq_q;
	logic [3:0]      bcnt_q;
	logic [1:0]      didx_q;
	logic [3:0][3:0] dig_q;
	logic [1:0]      st_q;
	logic            viol_q;
	logic            vld_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic            agree_s1;

	logic [1:0]      mem [TABLE_DEPTH];
	logic [1:0]      rd_q;

	always_comb begin
		n = cfg.param_count;
		if (n == 3'd0) n = 3'd1;
		if (n > 3'(mrct_pkg::MAX_PARAMS)) n = 3'(mrct_pkg::MAX_PARAMS);
		for (int p = 0; p < 4; p++) begin
			r[p] = cfg.radix[p];
			if (r[p] == 5'd0) r[p] = 5'd1;
			if (r[p] > 5'(mrct_pkg::MAX_VALUES)) r[p] = 5'(mrct_pkg::MAX_VALUES);
			act[p] = (3'(p) < n);
			bv[p]  = ({1'b0, vals_q[4*p +: 4]} >= r[p]) ? 4'(r[p] - 5'd1)
			                                            : vals_q[4*p +: 4];
		end
		lim = (cfg.table_range > DEPTH) ? DEPTH : cfg.table_range;
		em  = mask_q & act;
	end

	// agreement of scan digits and key digits with the binding
	logic [3:0] eq_k, eq_key;
	logic       agree_k, agree_key;
	always_comb begin
		for (int p = 0; p < 4; p++) begin
			eq_k[p]   = (cdig_q[p] == bv[p]);
			eq_key[p] = (dig_q[p] == bv[p]);
		end
		agree_k   = &(~em | eq_k);
		agree_key = &(~em | eq_key);
	end

	// mixed-radix increment, last active parameter least significant
	logic [3:0][3:0] cdig_n;
	logic            carry;
	always_comb begin
		carry  = 1'b1;
		cdig_n = cdig_q;
		for (int p = 3; p >= 0; p--) begin
			if (act[p] && carry) begin
				if ({1'b0, cdig_q[p]} == r[p] - 5'd1) begin
					cdig_n[p] = 4'd0;
				end else begin
					cdig_n[p] = cdig_q[p] + 4'd1;
					carry     = 1'b0;
				end
			end
		end
	end

	// restoring divide step
	logic [4:0] div_t, rq_n;
	logic       div_ge;
	assign div_t  = {rq_q[3:0], dq_q[15]};
	assign div_ge = (div_t >= r[didx_q]);
	assign rq_n   = div_ge ? div_t - r[didx_q] : div_t;

	// tuple key step
	logic [21:0] prod;
	logic [16:0] acc_n;
	assign prod  = 22'(acc_q) * 22'(r[pidx_q]);
	assign acc_n = prod[16:0] + 17'(bv[pidx_q]);

	// single cell address
	logic [16:0] sel;
	logic        inr;
	assign sel = (op_q == mrct_pkg::OP_MARK || op_q == mrct_pkg::OP_VIOL) ? acc_q
	                                                                     : {1'b0, key_q};
	assign inr = (sel < lim);

	assign stat.k_end     = (k_q == lim);
	assign stat.scan_end  = (k_q == lim) || wrap_q;
	assign stat.div_last  = (bcnt_q == 4'd15) && (didx_q == 2'd0);
	assign stat.kgen_last = ({1'b0, pidx_q} == n - 3'd1);

	logic fill_wr, excl_hit, cnt_hit, mark_hit, reopen_hit;
	assign fill_wr    = cmd.fill_step && !stat.k_end;
	assign excl_hit   = vld_s1 && (op_q == mrct_pkg::OP_EXCLUDE) && agree_s1;
	assign cnt_hit    = vld_s1 && (op_q == mrct_pkg::OP_COUNT) && agree_s1
	                    && (rd_q == mrct_pkg::MARK_OPEN);
	assign mark_hit   = cmd.eval && (op_q == mrct_pkg::OP_MARK) && inr
	                    && (rd_q == mrct_pkg::MARK_OPEN);
	assign reopen_hit = cmd.eval && (op_q == mrct_pkg::OP_REOPEN) && inr
	                    && (rd_q != mrct_pkg::MARK_OPEN);

	logic              we;
	logic [ADDR_W-1:0] wa, ra;
	logic [1:0]        wd;
	always_comb begin
		we = 1'b0;
		wa = k_q[ADDR_W-1:0];
		wd = fillm_q;
		if (fill_wr) begin
			we = 1'b1;
		end else if (excl_hit) begin
			we = 1'b1;
			wa = addr_s1;
			wd = mrct_pkg::MARK_EXCLUDED;
		end else if (mark_hit) begin
			we = 1'b1;
			wa = sel[ADDR_W-1:0];
			wd = mrct_pkg::MARK_COVERED;
		end else if (reopen_hit) begin
			we = 1'b1;
			wa = sel[ADDR_W-1:0];
			wd = mrct_pkg::MARK_OPEN;
		end
		ra = cmd.rd_issue ? sel[ADDR_W-1:0] : k_q[ADDR_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		rd_q <= mem[ra];
	end

	logic scan_go;
	assign scan_go = cmd.scan_step && !stat.scan_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= '0;
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= scan_go;
			if (cmd.load && mrct_pkg::op_t'(op) == mrct_pkg::OP_FILL) begin
				open_q <= (fill_status == mrct_pkg::MARK_OPEN) ? lim : '0;
			end else if ((excl_hit && rd_q == mrct_pkg::MARK_OPEN) || mark_hit) begin
				if (open_q != '0) open_q <= open_q - 17'd1;
			end else if (reopen_hit) begin
				if (open_q < DEPTH) open_q <= open_q + 17'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q      <= mrct_pkg::op_t'(op);
			key_q     <= key;
			mask_q    <= bound_mask;
			vals_q    <= bound_values;
			fillm_q   <= (fill_status == mrct_pkg::MARK_BAD) ? mrct_pkg::MARK_EXCLUDED
			                                                 : fill_status;
			k_q       <= '0;
			cdig_q    <= '0;
			wrap_q    <= 1'b0;
			matches_q <= '0;
			acc_q     <= '0;
			pidx_q    <= '0;
			dq_q      <= key;
			rq_q      <= '0;
			bcnt_q    <= '0;
			didx_q    <= 2'(n - 3'd1);
			dig_q     <= '0;
			st_q      <= '0;
			viol_q    <= 1'b0;
		end else begin
			if (fill_wr) k_q <= k_q + 17'd1;
			if (scan_go) begin
				k_q     <= k_q + 17'd1;
				cdig_q  <= cdig_n;
				wrap_q  <= carry;
				addr_s1 <= k_q[ADDR_W-1:0];
				agree_s1 <= agree_k;
			end
			if (cnt_hit) matches_q <= matches_q + 17'd1;
			if (cmd.kgen_step) begin
				acc_q  <= acc_n;
				pidx_q <= pidx_q + 2'd1;
			end
			if (cmd.div_step) begin
				dq_q   <= {dq_q[14:0], div_ge};
				bcnt_q <= bcnt_q + 4'd1;
				if (bcnt_q == 4'd15) begin
					dig_q[didx_q] <= rq_n[3:0];
					rq_q          <= '0;
					didx_q        <= didx_q - 2'd1;
				end else begin
					rq_q <= rq_n;
				end
			end
			if (cmd.eval) begin
				if (op_q == mrct_pkg::OP_CHECK) begin
					if (!inr || rd_q == mrct_pkg::MARK_EXCLUDED || !agree_key)
						st_q <= 2'd2;
					else
						st_q <= (rd_q == mrct_pkg::MARK_COVERED) ? 2'd1 : 2'd0;
				end
				viol_q <= inr && (rd_q == mrct_pkg::MARK_EXCLUDED);
			end
		end
	end

	logic [3:0] unb;
	assign unb = act & ~mask_q;

	always_comb begin
		res.key_status     = (op_q == mrct_pkg::OP_CHECK) ? st_q : 2'd0;
		res.open_matches   = (op_q == mrct_pkg::OP_COUNT) ? matches_q : 17'd0;
		res.decoded_values = (op_q == mrct_pkg::OP_DECODE) ? dig_q : 16'd0;
		res.newly_bound    = (op_q == mrct_pkg::OP_DECODE)
		                     ? 3'(unb[0]) + 3'(unb[1]) + 3'(unb[2]) + 3'(unb[3]) : 3'd0;
		res.violates       = (op_q == mrct_pkg::OP_VIOL) ? viol_q : 1'b0;
		res.open_total     = open_q;
	end

endmodule

@@ src/mixed_radix_coverage_table.sv @@
`timescale 1ns / 1ps
// Channel   Handshake              Payload
// req       req_valid/req_ready    op, key, bound_mask, bound_values, fill_status,
//                                  foreign_terms
// rsp       rsp_valid/rsp_ready    key_status, open_matches, decoded_values,
//                                  newly_bound, violates, open_total
// apb       psel/penable/pready    pwrite, paddr, pwdata, prdata
//
// One transaction at a time. Fill writes each cell below table_range; count and exclude
// scan min(product of active radices, table_range) cells, one cell per cycle through the
// single table read port (exclude with foreign terms skips the scan). Decode runs a serial
// divider, one quotient bit per cycle; check divides, then reads the cell; mark covered and
// violation test build the cell address, then read it; reopen reads the cell. Reset clears
// control and the open count; the cell table is not cleared and must be filled before
// use. A stalled response holds in the output register; the next request waits for it.
module mixed_radix_coverage_table #(
	parameter int TABLE_DEPTH = mrct_pkg::TABLE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// request
	input  logic        req_valid,
	output logic        req_ready,
	input  logic [2:0]  op,
	input  logic [15:0] key,
	input  logic [3:0]  bound_mask,
	input  logic [15:0] bound_values,
	input  logic [1:0]  fill_status,
	input  logic        foreign_terms,
	// response
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output logic [1:0]  key_status,
	output logic [16:0] open_matches,
	output logic [15:0] decoded_values,
	output logic [2:0]  newly_bound,
	output logic        violates,
	output logic [16:0] open_total,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	mrct_pkg::cfg_t    cfg_q;
	mrct_pkg::cmd_t    cmd;
	mrct_pkg::stat_t   stat;
	mrct_pkg::result_t res;
	mrct_pkg::result_t rsp_q;
	logic              rsp_valid_q;
	logic              rsp_load;
	logic [2:0]        reg_idx;
	logic              wr_en;

	// APB register file: write on the access phase, reads are zero-wait
	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.param_count <= 3'd2;
			cfg_q.radix       <= {5'd1, 5'd1, 5'd2, 5'd2};
			cfg_q.table_range <= 17'd4;
		end else if (wr_en) begin
			unique case (reg_idx)
				mrct_pkg::REG_PARAM_COUNT: cfg_q.param_count <= pwdata[2:0];
				mrct_pkg::REG_RADIX_0:     cfg_q.radix[0]    <= pwdata[4:0];
				mrct_pkg::REG_RADIX_1:     cfg_q.radix[1]    <= pwdata[4:0];
				mrct_pkg::REG_RADIX_2:     cfg_q.radix[2]    <= pwdata[4:0];
				mrct_pkg::REG_RADIX_3:     cfg_q.radix[3]    <= pwdata[4:0];
				mrct_pkg::REG_TABLE_RANGE: cfg_q.table_range <= pwdata[16:0];
				default: ;  // drop writes to unmapped addresses
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			mrct_pkg::REG_PARAM_COUNT: prdata = 32'(cfg_q.param_count);
			mrct_pkg::REG_RADIX_0:     prdata = 32'(cfg_q.radix[0]);
			mrct_pkg::REG_RADIX_1:     prdata = 32'(cfg_q.radix[1]);
			mrct_pkg::REG_RADIX_2:     prdata = 32'(cfg_q.radix[2]);
			mrct_pkg::REG_RADIX_3:     prdata = 32'(cfg_q.radix[3]);
			mrct_pkg::REG_TABLE_RANGE: prdata = 32'(cfg_q.table_range);
			default:                   prdata = 32'd0;
		endcase
	end

	// sequencer: walks each operation through the datapath
	mrct_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req_valid),
		.op            (op),
		.foreign_terms (foreign_terms),
		.rsp_valid     (rsp_valid_q),
		.rsp_ready     (rsp_ready),
		.stat          (stat),
		.req_ready     (req_ready),
		.cmd           (cmd),
		.rsp_load      (rsp_load)
	);

	// cell table, scan counters, divider and open count
	mrct_dpath #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.op           (op),
		.key          (key),
		.bound_mask   (bound_mask),
		.bound_values (bound_values),
		.fill_status  (fill_status),
		.cmd          (cmd),
		.stat         (stat),
		.res          (res)
	);

	// output register: hold the result until the consumer takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) rsp_q <= res;
	end

	assign rsp_valid      = rsp_valid_q;
	assign key_status     = rsp_q.key_status;
	assign open_matches   = rsp_q.open_matches;
	assign decoded_values = rsp_q.decoded_values;
	assign newly_bound    = rsp_q.newly_bound;
	assign violates       = rsp_q.violates;
	assign open_total     = rsp_q.open_total;

endmodule
